[src/cbsd_pkg.sv]
// shared types and constants for the can bit stuff / destuff block
// no dependencies; used by every module under src
`timescale 1ns / 1ps
`default_nettype none

package cbsd_pkg;

    localparam int DATA_W    = 8;
    localparam int LIM_W     = 11;
    localparam int TOTAL_W   = 11;
    localparam int MAX_RES   = 3;
    localparam int RES_IDX_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_OUT_BYTES_DEF = 1024;
    localparam int RUN_LIMIT_DEF     = 5;

    // prev bit code before any bit of the frame was seen
    localparam logic [1:0] NO_BIT = 2'd2;

    localparam logic MODE_STUFF   = 1'b0;
    localparam logic MODE_DESTUFF = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 1'd1;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd16;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               last;
        logic               ovf;
        logic [TOTAL_W-1:0] total;
    } res_t;

endpackage

`default_nettype wire

[src/can_bit_stuff_destuff_core.sv]
// top level of the can bit stuff / destuff block: input register, bit engine,
// result bundle register, config registers. depends on cbsd_pkg,
// cbsd_bit_engine, cbsd_result_buf
// a word waits in the input register; the result bundle register offers its results
// throughput: one word per cycle while each word yields at most one result and the
//   output never stalls; a word with more holds the engine till its last result leaves
// reset: async active low; clears frame state, mode to stuffing, out_limit to 16
`timescale 1ns / 1ps
`default_nettype none

module can_bit_stuff_destuff_core #(
    parameter int MAX_OUT_BYTES = cbsd_pkg::MAX_OUT_BYTES_DEF,
    parameter int RUN_LIMIT     = cbsd_pkg::RUN_LIMIT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [cbsd_pkg::DATA_W-1:0]     in_byte,
    input  wire logic                            last_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [cbsd_pkg::DATA_W-1:0]          out_byte,
    output logic                                 out_last,
    output logic                                 overflow,
    output logic [cbsd_pkg::TOTAL_W-1:0]         total_bytes,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cbsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbsd_pkg::LIM_W-1:0]      cfg_data
);

    logic                          in_vld_reg;
    logic [cbsd_pkg::DATA_W-1:0]   in_byte_reg;
    logic                          in_last_reg;
    logic                          mode_reg;
    logic [cbsd_pkg::LIM_W-1:0]    limit_reg;
    logic                          fire;
    logic                          free;
    cbsd_pkg::res_t                res [cbsd_pkg::MAX_RES];
    logic [cbsd_pkg::RES_IDX_W-1:0] nres;
    cbsd_pkg::res_t                out_res;

    assign fire      = in_vld_reg && free;
    assign in_ready  = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= last_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cbsd_pkg::MODE_STUFF;
            limit_reg <= cbsd_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbsd_pkg::REG_MODE:      mode_reg  <= cfg_data[0];
                cbsd_pkg::REG_OUT_LIMIT: limit_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    cbsd_bit_engine #(
        .MAX_OUT_BYTES (MAX_OUT_BYTES),
        .RUN_LIMIT     (RUN_LIMIT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .byte_in   (in_byte_reg),
        .last      (in_last_reg),
        .mode      (mode_reg),
        .out_limit (limit_reg),
        .res       (res),
        .nres      (nres)
    );

    cbsd_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .nres      (nres),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign out_byte    = out_res.data;
    assign out_last    = out_res.last;
    assign overflow    = out_res.ovf;
    assign total_bytes = out_res.total;

    // a word waiting on a full bundle keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !free) |=> (in_vld_reg && $stable(in_byte_reg) && $stable(in_last_reg)))
        else $error("held word changed while stalled");

endmodule

`default_nettype wire

[src/cbsd_bit_engine.sv]
// per-word bit engine: eight unrolled bit steps, stuffing or destuffing,
// byte packing and frame limit; holds the frame state. depends on cbsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbsd_bit_engine #(
    parameter int MAX_OUT_BYTES = cbsd_pkg::MAX_OUT_BYTES_DEF,
    parameter int RUN_LIMIT     = cbsd_pkg::RUN_LIMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [cbsd_pkg::DATA_W-1:0]   byte_in,
    input  wire logic                          last,
    input  wire logic                          mode,
    input  wire logic [cbsd_pkg::LIM_W-1:0]    out_limit,
    output cbsd_pkg::res_t                     res [cbsd_pkg::MAX_RES],
    output logic [cbsd_pkg::RES_IDX_W-1:0]     nres
);

    localparam int CNT_W = $clog2(MAX_OUT_BYTES + 1);
    localparam int CMP_W = (CNT_W > cbsd_pkg::LIM_W) ? CNT_W : cbsd_pkg::LIM_W;
    // run saturates one above the limit so a carried-over long run never re-triggers
    localparam int RUN_W = $clog2(RUN_LIMIT + 2);

    typedef struct packed {
        logic [7:0]       bits;
        logic [2:0]       cnt;
        logic [CNT_W-1:0] emitted;
        logic             aborted;
        logic             emit;
        logic [7:0]       emit_byte;
    } pk_t;

    logic [1:0]       prev_reg,    prev_next;
    logic [RUN_W-1:0] run_reg,     run_next;
    logic             skip_reg,    skip_next;
    logic [7:0]       bits_reg,    bits_next;
    logic [2:0]       cnt_reg,     cnt_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic             abort_reg,   abort_next;

    function automatic pk_t put_bit(pk_t s, logic b, logic [cbsd_pkg::LIM_W-1:0] lim);
        pk_t r;
        r = s;
        r.emit = 1'b0;
        r.emit_byte = '0;
        if (!s.aborted)
        begin
            if ((CMP_W'(s.emitted) >= CMP_W'(lim)) ||
                (CMP_W'(s.emitted) >= CMP_W'(MAX_OUT_BYTES)))
            begin
                r.aborted = 1'b1;
            end
            else if (s.cnt == 3'd7)
            begin
                r.emit      = 1'b1;
                r.emit_byte = {s.bits[6:0], b};
                r.bits      = '0;
                r.cnt       = '0;
                r.emitted   = CNT_W'(s.emitted + 1'b1);
            end
            else
            begin
                r.bits = {s.bits[6:0], b};
                r.cnt  = s.cnt + 3'd1;
            end
        end
        return r;
    endfunction

    always_comb
    begin : step
        pk_t              s;
        logic [1:0]       prev;
        logic [RUN_W-1:0] run;
        logic             skip;
        logic             b;
        s        = '0;
        s.bits   = bits_reg;
        s.cnt    = cnt_reg;
        s.emitted = emitted_reg;
        s.aborted = abort_reg;
        prev = prev_reg;
        run  = run_reg;
        skip = skip_reg;
        nres = '0;
        for (int k = 0; k < cbsd_pkg::MAX_RES; k++)
        begin
            res[k] = '0;
        end
        for (int i = 7; i >= 0; i--)
        begin
            b = byte_in[3'(i)];
            if (!s.aborted)
            begin
                if (mode == cbsd_pkg::MODE_STUFF)
                begin
                    s = put_bit(s, b, out_limit);
                    if (s.emit)
                    begin
                        res[nres].data = s.emit_byte;
                        nres = nres + 1'b1;
                    end
                    if ({1'b0, b} == prev)
                    begin
                        if (run <= RUN_W'(RUN_LIMIT))
                        begin
                            run = run + 1'b1;
                        end
                    end
                    else
                    begin
                        run  = RUN_W'(1);
                        prev = {1'b0, b};
                    end
                    if (run == RUN_W'(RUN_LIMIT))
                    begin
                        s = put_bit(s, ~b, out_limit);
                        if (s.emit)
                        begin
                            res[nres].data = s.emit_byte;
                            nres = nres + 1'b1;
                        end
                        prev = {1'b0, ~b};
                        run  = RUN_W'(1);
                    end
                end
                else if (skip)
                begin
                    // bit after a full run is dropped unchecked
                    skip = 1'b0;
                    prev = {1'b0, b};
                    run  = RUN_W'(1);
                end
                else
                begin
                    s = put_bit(s, b, out_limit);
                    if (s.emit)
                    begin
                        res[nres].data = s.emit_byte;
                        nres = nres + 1'b1;
                    end
                    if ({1'b0, b} == prev)
                    begin
                        if (run <= RUN_W'(RUN_LIMIT))
                        begin
                            run = run + 1'b1;
                        end
                    end
                    else
                    begin
                        run  = RUN_W'(1);
                        prev = {1'b0, b};
                    end
                    if (run == RUN_W'(RUN_LIMIT))
                    begin
                        skip = 1'b1;
                    end
                end
            end
        end

        if (last)
        begin
            if (s.aborted)
            begin
                res[nres] = '{data: '0, last: 1'b1, ovf: 1'b1, total: '0};
                nres = nres + 1'b1;
            end
            else if (s.cnt != 3'd0)
            begin
                res[nres].data  = s.bits << (4'd8 - {1'b0, s.cnt});
                res[nres].last  = 1'b1;
                res[nres].total = cbsd_pkg::TOTAL_W'(s.emitted + 1'b1);
                nres = nres + 1'b1;
            end
            else if (nres != '0)
            begin
                res[cbsd_pkg::RES_IDX_W'(nres - 1'b1)].last  = 1'b1;
                res[cbsd_pkg::RES_IDX_W'(nres - 1'b1)].total =
                    cbsd_pkg::TOTAL_W'(s.emitted);
            end
            else
            begin
                res[nres].last  = 1'b1;
                res[nres].total = cbsd_pkg::TOTAL_W'(s.emitted);
                nres = nres + 1'b1;
            end
            prev_next    = cbsd_pkg::NO_BIT;
            run_next     = '0;
            skip_next    = 1'b0;
            bits_next    = '0;
            cnt_next     = '0;
            emitted_next = '0;
            abort_next   = 1'b0;
        end
        else
        begin
            prev_next    = prev;
            run_next     = run;
            skip_next    = skip;
            bits_next    = s.bits;
            cnt_next     = s.cnt;
            emitted_next = s.emitted;
            abort_next   = s.aborted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= cbsd_pkg::NO_BIT;
            run_reg     <= '0;
            skip_reg    <= 1'b0;
            bits_reg    <= '0;
            cnt_reg     <= '0;
            emitted_reg <= '0;
            abort_reg   <= 1'b0;
        end
        else if (fire)
        begin
            prev_reg    <= prev_next;
            run_reg     <= run_next;
            skip_reg    <= skip_next;
            bits_reg    <= bits_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
            abort_reg   <= abort_next;
        end
    end

    // a last word always closes the frame with at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last) |-> (nres != '0))
        else $error("last word produced no result");

    // the frame state is clean right after a last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last) |=> (!abort_reg && (cnt_reg == 3'd0) && (emitted_reg == '0)))
        else $error("frame state not cleared after last word");

endmodule

`default_nettype wire

[src/cbsd_result_buf.sv]
// result bundle register: holds up to three results of one word and
// hands them out one per cycle while out_ready is high. depends on cbsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbsd_result_buf (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire cbsd_pkg::res_t                res [cbsd_pkg::MAX_RES],
    input  wire logic [cbsd_pkg::RES_IDX_W-1:0] nres,
    output logic                               free,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cbsd_pkg::res_t                     out_res
);

    cbsd_pkg::res_t                  ent_reg [cbsd_pkg::MAX_RES];
    logic [cbsd_pkg::RES_IDX_W-1:0]  rem_reg, rem_next;
    logic                            take;

    assign out_valid = (rem_reg != '0);
    assign take      = out_valid && out_ready;
    // room for a new bundle once the last pending word leaves this cycle
    assign free      = (rem_reg == '0) || ((rem_reg == 2'd1) && out_ready);
    assign out_res   = ent_reg[0];

    always_comb
    begin
        rem_next = rem_reg;
        if (load)
        begin
            rem_next = nres;
        end
        else if (take)
        begin
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < cbsd_pkg::MAX_RES; k++)
            begin
                ent_reg[k] <= res[k];
            end
        end
        else if (take)
        begin
            for (int k = 0; k < cbsd_pkg::MAX_RES - 1; k++)
            begin
                ent_reg[k] <= ent_reg[k + 1];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("bundle loaded over pending results");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (rem_reg > 2'd1)) |=> out_valid)
        else $error("pending results lost");

endmodule

`default_nettype wire

[sim/cbsd_frame_checker.sv]
// checker for the can bit stuff / destuff core: follows config writes and input words,
// predicts the coded bytes of every frame and compares each output word against them
// depends on cbsd_pkg
`timescale 1ns / 1ps

module cbsd_frame_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [cbsd_pkg::DATA_W-1:0]   in_byte,
    input  wire logic                          last_in,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [cbsd_pkg::DATA_W-1:0]   out_byte,
    input  wire logic                          out_last,
    input  wire logic                          overflow,
    input  wire logic [cbsd_pkg::TOTAL_W-1:0]  total_bytes,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [cbsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cbsd_pkg::LIM_W-1:0]    cfg_data,
    output int                                 mismatch_total,
    output int                                 coded_due_count,
    output int                                 bytes_compared,
    output int                                 overflow_seen,
    output int                                 frames_seen
);

    localparam int PRINT_CAP = 40;

    // shadow of the block's registers and frame state
    logic                         shadow_mode;
    logic [cbsd_pkg::LIM_W-1:0]   shadow_limit;
    logic [1:0]                   run_bit;
    int unsigned                  run_len;
    logic                         skip_pending;
    logic [cbsd_pkg::DATA_W-1:0]  acc_bits;
    logic [3:0]                   acc_cnt;
    logic [cbsd_pkg::TOTAL_W-1:0] frame_bytes;
    logic                         frame_abort;
    int                           word_results;

    cbsd_pkg::res_t coded_bytes_due[$];
    cbsd_pkg::res_t staged;
    cbsd_pkg::res_t seen;
    int   mismatches;
    int   compared;
    int   aborts;
    int   frames;

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: mismatch on %s, expected %0d got %0d", $time, what, want, got);
    endtask

    task automatic restart_frame();
        run_bit      = cbsd_pkg::NO_BIT;
        run_len      = 0;
        skip_pending = 1'b0;
        acc_bits     = '0;
        acc_cnt      = '0;
        frame_bytes  = '0;
        frame_abort  = 1'b0;
    endtask

    task automatic queue_coded(input logic [cbsd_pkg::DATA_W-1:0] data, input logic fin,
                               input logic ovf, input logic [cbsd_pkg::TOTAL_W-1:0] total);
        staged       = '0;
        staged.data  = data;
        staged.last  = fin;
        staged.ovf   = ovf;
        staged.total = total;
        coded_bytes_due.push_back(staged);
        word_results++;
    endtask

    task automatic pack_bit(input logic b);
        logic [cbsd_pkg::LIM_W-1:0] cap;
        cap = (shadow_limit > cbsd_pkg::LIM_W'(cbsd_pkg::MAX_OUT_BYTES_DEF))
            ? cbsd_pkg::LIM_W'(cbsd_pkg::MAX_OUT_BYTES_DEF) : shadow_limit;
        if (frame_abort)
            return;
        if (frame_bytes >= cap) begin
            frame_abort = 1'b1;
            return;
        end
        acc_bits = {acc_bits[cbsd_pkg::DATA_W-2:0], b};
        acc_cnt++;
        if (acc_cnt == 4'd8) begin
            queue_coded(acc_bits, 1'b0, 1'b0, '0);
            frame_bytes++;
            acc_bits = '0;
            acc_cnt  = '0;
        end
    endtask

    task automatic note_run(input logic b);
        if ({1'b0, b} == run_bit) begin
            run_len++;
        end
        else begin
            run_len = 1;
            run_bit = {1'b0, b};
        end
    endtask

    task automatic predict_coded_bytes(input logic [cbsd_pkg::DATA_W-1:0] word_bits,
                                       input logic fin);
        logic b;
        word_results = 0;
        for (int i = cbsd_pkg::DATA_W - 1; i >= 0; i--) begin
            b = word_bits[i];
            if (frame_abort)
                break;
            if (shadow_mode == cbsd_pkg::MODE_STUFF) begin
                pack_bit(b);
                note_run(b);
                // inserted bit opens a fresh run
                if (run_len == cbsd_pkg::RUN_LIMIT_DEF) begin
                    pack_bit(~b);
                    run_bit = {1'b0, ~b};
                    run_len = 1;
                end
            end
            else if (skip_pending) begin
                // dropped unchecked, but it still starts a run
                skip_pending = 1'b0;
                run_bit      = {1'b0, b};
                run_len      = 1;
            end
            else begin
                pack_bit(b);
                note_run(b);
                if (run_len == cbsd_pkg::RUN_LIMIT_DEF)
                    skip_pending = 1'b1;
            end
        end
        if (fin) begin
            if (frame_abort) begin
                queue_coded('0, 1'b1, 1'b1, '0);
            end
            else if (acc_cnt > 0) begin
                queue_coded(acc_bits << (4'd8 - acc_cnt), 1'b1, 1'b0, frame_bytes + 1'b1);
            end
            else if (word_results > 0) begin
                // frame ends on a byte boundary: the last full byte carries the count
                staged       = coded_bytes_due[coded_bytes_due.size() - 1];
                staged.last  = 1'b1;
                staged.total = frame_bytes;
                coded_bytes_due[coded_bytes_due.size() - 1] = staged;
            end
            else begin
                queue_coded('0, 1'b1, 1'b0, frame_bytes);
            end
            restart_frame();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_mode  = cbsd_pkg::MODE_STUFF;
            shadow_limit = cbsd_pkg::LIMIT_RESET;
            restart_frame();
            coded_bytes_due.delete();
            mismatches = 0;
            compared   = 0;
            aborts     = 0;
            frames     = 0;
            mismatch_total  <= 0;
            coded_due_count <= 0;
            bytes_compared  <= 0;
            overflow_seen   <= 0;
            frames_seen     <= 0;
        end
        else begin
            // compare first: an output word at this edge never belongs to this edge's input
            if (out_valid && out_ready) begin
                compared++;
                if (coded_bytes_due.size() == 0) begin
                    report("output word with nothing expected, out_byte", 32'hFFFF_FFFF,
                           out_byte);
                end
                else begin
                    seen = coded_bytes_due.pop_front();
                    if (seen.ovf)
                        aborts++;
                    if (out_byte !== seen.data)
                        report("out_byte", seen.data, out_byte);
                    if (out_last !== seen.last)
                        report("out_last", seen.last, out_last);
                    if (overflow !== seen.ovf)
                        report("overflow", seen.ovf, overflow);
                    if (total_bytes !== seen.total)
                        report("total_bytes", seen.total, total_bytes);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cbsd_pkg::REG_MODE)
                    shadow_mode = cfg_data[0];
                else if (cfg_index == cbsd_pkg::REG_OUT_LIMIT)
                    shadow_limit = cfg_data;
            end
            if (in_valid && in_ready) begin
                predict_coded_bytes(in_byte, last_in);
                if (last_in)
                    frames++;
            end
            mismatch_total  <= mismatches;
            coded_due_count <= coded_bytes_due.size();
            bytes_compared  <= compared;
            overflow_seen   <= aborts;
            frames_seen     <= frames;
        end
    end

endmodule

[sim/can_bit_stuff_destuff_core_tb.sv]
// testbench top for the can bit stuff / destuff core: clock, reset, word and config
// stimulus, output stalls and the verdict. depends on cbsd_pkg,
// can_bit_stuff_destuff_core and cbsd_frame_checker
`timescale 1ns / 1ps

module can_bit_stuff_destuff_core_tb;

    localparam int          RANDOM_WORDS = 410;
    localparam int          IDLE_SETTLE  = 8;
    localparam int          HOLD_CYCLES  = 100;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [cbsd_pkg::DATA_W-1:0]    in_byte;
    logic                           last_in;
    logic                           out_valid;
    logic                           out_ready;
    logic [cbsd_pkg::DATA_W-1:0]    out_byte;
    logic                           out_last;
    logic                           overflow;
    logic [cbsd_pkg::TOTAL_W-1:0]   total_bytes;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cbsd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cbsd_pkg::LIM_W-1:0]     cfg_data;

    int          mismatch_total;
    int          coded_due_count;
    int          bytes_compared;
    int          overflow_seen;
    int          frames_seen;
    int          words_sent;
    int          burst_left;
    int          hold_requests;
    int          holds_done;
    int unsigned cycle_count;

    can_bit_stuff_destuff_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .overflow    (overflow),
        .total_bytes (total_bytes),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    cbsd_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .last_in         (last_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .overflow        (overflow),
        .total_bytes     (total_bytes),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_total  (mismatch_total),
        .coded_due_count (coded_due_count),
        .bytes_compared  (bytes_compared),
        .overflow_seen   (overflow_seen),
        .frames_seen     (frames_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d output words still due",
                     cycle_count, coded_due_count);
            $display("status: fail");
            $finish;
        end
    end

    // send one word; bursts of random length separated by random gaps
    task automatic send_word(input logic [cbsd_pkg::DATA_W-1:0] b, input logic fin);
        int gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        last_in  <= fin;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // stop offering words and let every due output word drain
    task automatic wait_idle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (coded_due_count != 0) @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [cbsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbsd_pkg::LIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // receiver: stall style changes after each random span, long hold on request
    initial begin : rx_stall
        int style;
        int span;
        int tick;
        out_ready = 1'b0;
        holds_done = 0;
        tick = 0;
        wait (rst_n === 1'b1);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 80);
            repeat (span) begin
                @(posedge clk);
                if (holds_done != hold_requests) begin
                    holds_done++;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                tick++;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 1) == 0);
                    default: out_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int                          k;
        int                          len;
        int                          phase_frames;
        int                          random_start;
        logic [cbsd_pkg::DATA_W-1:0] b;
        logic [cbsd_pkg::LIM_W-1:0]  lim;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = '0;
        last_in       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = cbsd_pkg::REG_MODE;
        cfg_data      = '0;
        cycle_count   = 0;
        words_sent    = 0;
        burst_left    = 0;
        hold_requests = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // reset settings: stuffing, limit 16; long runs of both polarities
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hAA, 1'b1);
        send_word(8'hF8, 1'b1);
        // a limit of one byte is crossed by the stuff bits
        wait_idle();
        write_reg(cbsd_pkg::REG_OUT_LIMIT, 11'd1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        // zero limit aborts on the first bit
        wait_idle();
        write_reg(cbsd_pkg::REG_OUT_LIMIT, 11'd0);
        send_word(8'h55, 1'b1);
        // limit above the maximum acts as the maximum
        wait_idle();
        write_reg(cbsd_pkg::REG_OUT_LIMIT, 11'h7FF);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h0F, 1'b1);
        // destuffing; upper data bits of the mode write are don't care
        wait_idle();
        write_reg(cbsd_pkg::REG_MODE, {10'h3FF, cbsd_pkg::MODE_DESTUFF});
        write_reg(cbsd_pkg::REG_OUT_LIMIT, 11'd1024);
        send_word(8'h55, 1'b1);
        send_word(8'h07, 1'b0);
        send_word(8'hC1, 1'b0);
        send_word(8'hF0, 1'b1);
        // five ones close the word, so a drop is pending when the mode flips mid-frame
        send_word(8'h1F, 1'b0);
        wait_idle();
        write_reg(cbsd_pkg::REG_MODE, {10'd0, cbsd_pkg::MODE_STUFF});
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b0);
        wait_idle();
        write_reg(cbsd_pkg::REG_MODE, {10'd0, cbsd_pkg::MODE_DESTUFF});
        send_word(8'h00, 1'b1);
        // destuffed frame overflowing a two-byte limit
        wait_idle();
        write_reg(cbsd_pkg::REG_OUT_LIMIT, 11'd2);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);

        // long output hold while the sender keeps pushing: the core fills and stalls
        random_start = words_sent;
        wait_idle();
        write_reg(cbsd_pkg::REG_MODE, {10'd0, cbsd_pkg::MODE_STUFF});
        write_reg(cbsd_pkg::REG_OUT_LIMIT, 11'd1024);
        hold_requests++;
        burst_left = 64;
        for (k = 0; k < 40; k++)
            send_word(8'($urandom), k == 39);

        phase_frames = 0;
        while (words_sent < random_start + RANDOM_WORDS) begin
            if (phase_frames == 0) begin
                wait_idle();
                write_reg(cbsd_pkg::REG_MODE, cbsd_pkg::LIM_W'($urandom));
                case ($urandom_range(0, 11))
                    0:       lim = '0;
                    1:       lim = 11'h7FF;
                    2:       lim = 11'd1024;
                    3:       lim = 11'($urandom_range(1025, 2046));
                    4:       lim = 11'($urandom_range(1, 1023));
                    default: lim = 11'($urandom_range(1, 12));
                endcase
                write_reg(cbsd_pkg::REG_OUT_LIMIT, lim);
                phase_frames = $urandom_range(2, 6);
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    2:       b = 8'h1F;
                    3:       b = 8'hF8;
                    4:       b = 8'h07;
                    5:       b = 8'hE0;
                    default: b = 8'($urandom);
                endcase
                // occasional mode change in the middle of a frame
                if (k > 0 && $urandom_range(0, 39) == 0) begin
                    wait_idle();
                    write_reg(cbsd_pkg::REG_MODE, cbsd_pkg::LIM_W'($urandom));
                end
                send_word(b, k == len - 1);
            end
            phase_frames--;
        end

        wait_idle();
        $display("covered %0d words in %0d frames over both modes and many limits",
                 words_sent, frames_seen);
        $display("compared %0d output words, %0d of them overflow aborts",
                 bytes_compared, overflow_seen);
        if (mismatch_total == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[can_bit_stuff_destuff_core.f]
src/cbsd_pkg.sv
src/cbsd_bit_engine.sv
src/cbsd_result_buf.sv
src/can_bit_stuff_destuff_core.sv
sim/cbsd_frame_checker.sv
sim/can_bit_stuff_destuff_core_tb.sv
